// ===== design/ile_pkg.sv =====
// ile_pkg: shared constants, types and codes for the indexed list engine.
// No dependencies; imported by every module of the block.
package ile_pkg;

  localparam int Depth      = 64;
  localparam int ElemWidth  = 32;
  localparam int IdxW       = $clog2(Depth);
  localparam int CntW       = $clog2(Depth + 1);
  localparam int GroupSize  = 8;
  localparam int NumGroups  = (Depth + GroupSize - 1) / GroupSize;

  localparam int ModeW      = 4;
  localparam int ValueW     = 32;
  localparam int IndexW     = 7;
  localparam int StatusW    = 2;
  localparam int DataW      = 32;
  localparam int InTdataW   = 48;
  localparam int OutTdataW  = 48;

  typedef logic [ElemWidth-1:0] elem_t;
  typedef logic [IdxW-1:0]      pos_t;
  typedef logic [CntW-1:0]      cnt_t;

  typedef enum logic [ModeW-1:0] {
    MODE_INS_HEAD = 4'd0,
    MODE_INS_TAIL = 4'd1,
    MODE_INS_IDX  = 4'd2,
    MODE_RM_HEAD  = 4'd3,
    MODE_RM_TAIL  = 4'd4,
    MODE_RM_IDX   = 4'd5,
    MODE_READ     = 4'd6,
    MODE_REPLACE  = 4'd7,
    MODE_SEARCH   = 4'd8,
    MODE_COMPARE  = 4'd9,
    MODE_CLEAR    = 4'd10
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_WR   = 2'd3
  } cell_op_e;

  // Broadcast control seen by every cell of the row.
  typedef struct packed {
    cell_op_e op;
    pos_t     pos;
    elem_t    value;
    logic     tap_en;
    logic     rd_en;
    logic     cmp_en;
    logic     srch_en;
    cnt_t     occ;
  } cell_ctrl_t;

endpackage

// ===== design/indexed_list_engine.sv =====
// indexed_list_engine: ordered list of up to Depth elements in a row of cells.
// Each command passes through the cell tap registers, the registered OR tree stage
// and the output register; no new command is accepted until its result word is
// loaded. A result waiting on m_axis_tready keeps the input closed.
// Inserts, removes, replaces and clear take effect at the accept edge.
// Reset (rst_ni low, async) empties the list and drops any pending result;
// cell contents are not cleared and are never read beyond the count.
module indexed_list_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fields from bit 0: mode[3:0], value[35:4], index[42:36], zero pad
  input  logic [ile_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // fields from bit 0: status[1:0], data[33:2], found[34], count[41:35],
  // empty_res[42], zero pad
  output logic [ile_pkg::OutTdataW-1:0] m_axis_tdata
);
  import ile_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // unpacked input word
  logic [ModeW-1:0]  in_mode;
  logic [ValueW-1:0] in_value;
  logic [IndexW-1:0] in_index;
  logic              in_acc;

  assign in_mode  = s_axis_tdata[ModeW-1:0];
  assign in_value = s_axis_tdata[ModeW+ValueW-1:ModeW];
  assign in_index = s_axis_tdata[ModeW+ValueW+IndexW-1:ModeW+ValueW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // list occupancy
  cnt_t occ_q, occ_d;

  // result fields held until the tree finishes
  status_e st_q, st_d;
  cnt_t    cnt_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  cell_ctrl_t ctrl;
  status_e    status;
  logic       is_full;

  assign is_full = (occ_q >= cnt_t'(Depth));

  // Decode one command against the current count.
  always_comb begin
    ctrl         = '0;
    ctrl.op      = CELL_HOLD;
    ctrl.value   = in_value[ElemWidth-1:0];
    ctrl.tap_en  = in_acc;
    ctrl.occ     = occ_q;
    status       = ST_OK;
    occ_d        = occ_q;
    case (mode_e'(in_mode))
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_IDX: begin
        if (mode_e'(in_mode) == MODE_INS_IDX && in_index > occ_q) begin
          status = ST_RANGE;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_INS;
          occ_d   = occ_q + cnt_t'(1);
          case (mode_e'(in_mode))
            MODE_INS_HEAD: ctrl.pos = '0;
            MODE_INS_TAIL: ctrl.pos = occ_q[IdxW-1:0];
            default:       ctrl.pos = in_index[IdxW-1:0];
          endcase
        end
      end
      MODE_RM_HEAD, MODE_RM_TAIL: begin
        if (occ_q == '0) begin
          status = ST_EMPTY;
        end else begin
          ctrl.op  = CELL_DEL;
          occ_d    = occ_q - cnt_t'(1);
          ctrl.pos = (mode_e'(in_mode) == MODE_RM_HEAD) ? '0 : occ_d[IdxW-1:0];
        end
      end
      MODE_RM_IDX, MODE_READ, MODE_REPLACE, MODE_COMPARE: begin
        if (in_index >= occ_q) begin
          status = ST_RANGE;
        end else begin
          ctrl.pos = in_index[IdxW-1:0];
          case (mode_e'(in_mode))
            MODE_RM_IDX: begin
              ctrl.op = CELL_DEL;
              occ_d   = occ_q - cnt_t'(1);
            end
            MODE_READ:    ctrl.rd_en  = 1'b1;
            MODE_REPLACE: ctrl.op     = CELL_WR;
            default:      ctrl.cmp_en = 1'b1;
          endcase
        end
      end
      MODE_SEARCH: begin
        ctrl.srch_en = 1'b1;
      end
      MODE_CLEAR: begin
        occ_d = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (!in_acc) begin
      ctrl.op = CELL_HOLD;
      occ_d   = occ_q;
    end
  end

  assign st_d = in_acc ? status : st_q;

  // cell row
  elem_t entry     [Depth];
  elem_t tap_data  [Depth];
  logic  tap_match [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    elem_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[k-1];
    end
    if (k == Depth - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[k+1];
    end
    ile_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (pos_t'(k)),
      .ctrl_i      (ctrl),
      .left_i      (left_w),
      .right_i     (right_w),
      .entry_o     (entry[k]),
      .tap_data_o  (tap_data[k]),
      .tap_match_o (tap_match[k])
    );
  end

  elem_t red_data;
  logic  red_match;

  ile_reduce u_reduce (
    .clk_i       (clk_i),
    .tap_data_i  (tap_data),
    .tap_match_i (tap_match),
    .data_o      (red_data),
    .match_o     (red_match)
  );

  // sequencing: accept, let the tree settle, then load the output word
  logic load_out;

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_GATHER;
      S_GATHER: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  // result word assembled from the held fields and the tree output
  always_comb begin
    out_data_d = '0;
    out_data_d[StatusW-1:0]                        = st_q;
    out_data_d[StatusW+DataW-1:StatusW]            = DataW'(red_data);
    out_data_d[StatusW+DataW]                      = red_match;
    out_data_d[StatusW+DataW+CntW:StatusW+DataW+1] = cnt_q;
    out_data_d[StatusW+DataW+CntW+1]               = (cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      st_q        <= ST_OK;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) cnt_q <= occ_d;
    if (load_out) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/ile_cell.sv =====
// ile_cell: one list position; shifts with its neighbors, writes and compares.
// Depends on ile_pkg.
module ile_cell (
  input  logic              clk_i,
  input  ile_pkg::pos_t     cell_idx_i,
  input  ile_pkg::cell_ctrl_t ctrl_i,
  input  ile_pkg::elem_t    left_i,
  input  ile_pkg::elem_t    right_i,
  output ile_pkg::elem_t    entry_o,
  output ile_pkg::elem_t    tap_data_o,
  output logic              tap_match_o
);
  import ile_pkg::*;

  elem_t entry_q, entry_d;
  elem_t tap_data_q, tap_data_d;
  logic  tap_match_q, tap_match_d;
  logic  at_pos, in_list;

  assign at_pos  = (cell_idx_i == ctrl_i.pos);
  assign in_list = ({1'b0, cell_idx_i} < ctrl_i.occ);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (cell_idx_i > ctrl_i.pos) begin
          entry_d = left_i;
        end else if (at_pos) begin
          entry_d = ctrl_i.value;
        end
      end
      CELL_DEL: begin
        if (cell_idx_i >= ctrl_i.pos) begin
          entry_d = right_i;
        end
      end
      CELL_WR: begin
        if (at_pos) begin
          entry_d = ctrl_i.value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // taps look at the contents before this word's update
  always_comb begin
    tap_data_d  = tap_data_q;
    tap_match_d = tap_match_q;
    if (ctrl_i.tap_en) begin
      tap_data_d  = (ctrl_i.rd_en && at_pos) ? entry_q : '0;
      tap_match_d = (entry_q == ctrl_i.value) &&
                    ((ctrl_i.cmp_en && at_pos) || (ctrl_i.srch_en && in_list));
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q     <= entry_d;
    tap_data_q  <= tap_data_d;
    tap_match_q <= tap_match_d;
  end

  assign entry_o     = entry_q;
  assign tap_data_o  = tap_data_q;
  assign tap_match_o = tap_match_q;

endmodule

// ===== design/ile_reduce.sv =====
// ile_reduce: registered OR tree that gathers the cell taps into one answer.
// Depends on ile_pkg.
module ile_reduce (
  input  logic           clk_i,
  input  ile_pkg::elem_t tap_data_i  [ile_pkg::Depth],
  input  logic           tap_match_i [ile_pkg::Depth],
  output ile_pkg::elem_t data_o,
  output logic           match_o
);
  import ile_pkg::*;

  elem_t grp_data_q  [NumGroups];
  logic  grp_match_q [NumGroups];
  elem_t grp_data_d  [NumGroups];
  logic  grp_match_d [NumGroups];

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_data_d[g]  = '0;
      grp_match_d[g] = 1'b0;
      for (int j = 0; j < GroupSize; j++) begin
        if (g * GroupSize + j < Depth) begin
          grp_data_d[g]  = grp_data_d[g] | tap_data_i[g * GroupSize + j];
          grp_match_d[g] = grp_match_d[g] | tap_match_i[g * GroupSize + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_data_q[g]  <= grp_data_d[g];
      grp_match_q[g] <= grp_match_d[g];
    end
  end

  always_comb begin
    data_o  = '0;
    match_o = 1'b0;
    for (int g = 0; g < NumGroups; g++) begin
      data_o  = data_o | grp_data_q[g];
      match_o = match_o | grp_match_q[g];
    end
  end

endmodule
